// ----- rtl/core/avcc_record_parser_macros.svh -----
// assertion macros for the avcc record parser checker
`ifndef AVCC_RECORD_PARSER_MACROS_SVH
`define AVCC_RECORD_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define AVCC_RP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define AVCC_RP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/avcc_rp_pkg.sv -----
// types and constants shared by the avcc record parser
package avcc_rp_pkg;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_SPS_HI    = 4'd1,
    PH_SPS_LO    = 4'd2,
    PH_SPS_FIRST = 4'd3,
    PH_SPS_BODY  = 4'd4,
    PH_PPS_COUNT = 4'd5,
    PH_PPS_HI    = 4'd6,
    PH_PPS_LO    = 4'd7,
    PH_PPS_FIRST = 4'd8,
    PH_PPS_BODY  = 4'd9,
    PH_TRAILER   = 4'd10,
    PH_HALT      = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HDR = 2'd0,
    KIND_SPS = 2'd1,
    KIND_PPS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_VERSION = 2'd1,
    ST_TRUNCATED   = 2'd2
  } status_e;

  localparam logic [2:0] HdrVersionPos = 3'd0;
  localparam logic [2:0] HdrLenPos     = 3'd4;
  localparam logic [2:0] HdrSpsPos     = 3'd5;
  localparam logic [7:0] VersionOne    = 8'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload;
    logic       unit_start;
    logic       unit_end;
    logic       record_done;
    status_e    status;
    logic [2:0] length_size;
    logic [4:0] sps_total;
    logic [7:0] pps_total;
  } out_beat_t;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  header_pos;
    logic [7:0]  units_left;
    logic [15:0] bytes_left;
    logic [7:0]  length_high;
    logic [2:0]  length_size;
    logic        bad_version;
    logic [4:0]  sps_count;
    logic [7:0]  pps_count;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase:       PH_HEADER,
    header_pos:  3'd0,
    units_left:  8'd0,
    bytes_left:  16'd0,
    length_high: 8'd0,
    length_size: 3'd0,
    bad_version: 1'b0,
    sps_count:   5'd0,
    pps_count:   8'd0
  };

endpackage

// ----- rtl/core/avcc_rp_step.sv -----
// next-state and result logic for one record byte
module avcc_rp_step (
  input  avcc_rp_pkg::parse_state_t cur_i,
  input  avcc_rp_pkg::in_beat_t     beat_i,
  output avcc_rp_pkg::parse_state_t nxt_o,
  output avcc_rp_pkg::out_beat_t    res_o
);
  import avcc_rp_pkg::*;

  parse_state_t nxt;
  out_beat_t    res;
  logic [7:0]   units_dec;
  logic [15:0]  len_word;
  logic [15:0]  bytes_dec;
  logic         is_pps;
  status_e      status;

  always_comb begin
    nxt       = cur_i;
    res       = '0;
    units_dec = (cur_i.units_left != 8'd0) ? (cur_i.units_left - 8'd1) : cur_i.units_left;
    len_word  = {cur_i.length_high, beat_i.data_byte};
    bytes_dec = cur_i.bytes_left - 16'd1;
    is_pps    = cur_i.phase inside {PH_PPS_HI, PH_PPS_LO, PH_PPS_FIRST, PH_PPS_BODY};
    status    = ST_OK;

    case (cur_i.phase)
      PH_HEADER: begin
        if (cur_i.header_pos == HdrVersionPos && beat_i.data_byte != VersionOne) begin
          nxt.bad_version = 1'b1;
          nxt.phase       = PH_HALT;
        end else begin
          if (cur_i.header_pos == HdrLenPos) begin
            nxt.length_size = {1'b0, beat_i.data_byte[1:0]} + 3'd1;
          end
          if (cur_i.header_pos >= HdrSpsPos) begin
            nxt.sps_count  = beat_i.data_byte[4:0];
            nxt.units_left = {3'b000, beat_i.data_byte[4:0]};
            nxt.phase      = (beat_i.data_byte[4:0] != 5'd0) ? PH_SPS_HI : PH_PPS_COUNT;
          end else begin
            nxt.header_pos = cur_i.header_pos + 3'd1;
          end
        end
      end
      PH_SPS_HI, PH_PPS_HI: begin
        nxt.length_high = beat_i.data_byte;
        nxt.phase       = is_pps ? PH_PPS_LO : PH_SPS_LO;
      end
      PH_SPS_LO, PH_PPS_LO: begin
        nxt.bytes_left = len_word;
        if (len_word == 16'd0) begin
          nxt.units_left = units_dec;
          if (is_pps) begin
            nxt.phase = (units_dec == 8'd0) ? PH_TRAILER : PH_PPS_HI;
          end else begin
            nxt.phase = (units_dec == 8'd0) ? PH_PPS_COUNT : PH_SPS_HI;
          end
        end else begin
          nxt.phase = is_pps ? PH_PPS_FIRST : PH_SPS_FIRST;
        end
      end
      PH_SPS_FIRST, PH_SPS_BODY, PH_PPS_FIRST, PH_PPS_BODY: begin
        res.kind       = is_pps ? KIND_PPS : KIND_SPS;
        res.payload    = beat_i.data_byte;
        res.unit_start = cur_i.phase inside {PH_SPS_FIRST, PH_PPS_FIRST};
        nxt.bytes_left = bytes_dec;
        if (bytes_dec == 16'd0) begin
          res.unit_end   = 1'b1;
          nxt.units_left = units_dec;
          if (is_pps) begin
            nxt.phase = (units_dec == 8'd0) ? PH_TRAILER : PH_PPS_HI;
          end else begin
            nxt.phase = (units_dec == 8'd0) ? PH_PPS_COUNT : PH_SPS_HI;
          end
        end else begin
          nxt.phase = is_pps ? PH_PPS_BODY : PH_SPS_BODY;
        end
      end
      PH_PPS_COUNT: begin
        nxt.pps_count  = beat_i.data_byte;
        nxt.units_left = beat_i.data_byte;
        nxt.phase      = (beat_i.data_byte != 8'd0) ? PH_PPS_HI : PH_TRAILER;
      end
      default: begin
      end
    endcase

    res.record_done = beat_i.last;
    if (beat_i.last) begin
      if (nxt.bad_version) begin
        status = ST_BAD_VERSION;
      end else if (nxt.phase == PH_TRAILER) begin
        status = ST_OK;
      end else begin
        status = ST_TRUNCATED;
      end
      res.status      = status;
      res.length_size = (status == ST_OK) ? nxt.length_size : 3'd0;
      res.sps_total   = nxt.sps_count;
      res.pps_total   = nxt.pps_count;
      nxt             = StateReset;
    end
  end

  assign nxt_o = nxt;
  assign res_o = res;

endmodule

// ----- rtl/core/avcc_rp_core.sv -----
// parser state register around the per-byte step logic
module avcc_rp_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_en_i,
  input  avcc_rp_pkg::in_beat_t  beat_i,
  output avcc_rp_pkg::out_beat_t res_o
);
  import avcc_rp_pkg::*;

  parse_state_t state_q;
  parse_state_t state_d;

  avcc_rp_step u_step (
    .cur_i  (state_q),
    .beat_i (beat_i),
    .nxt_o  (state_d),
    .res_o  (res_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (step_en_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/avcc_record_parser.sv -----
// top level of the avcc record parser
// Takes an avcC configuration record one byte per beat, last set on its final
// byte, and returns exactly one result beat per input beat: SPS and PPS
// payload bytes tagged by kind with unit start and end marks, and on the last
// byte the status, NAL length size and unit counts. Sustained rate is one byte
// per cycle while the result is not stalled; each byte is held in the input
// register, and its result beat is loaded into the result register when that
// register is free or being taken. The rate is set by the parser state update
// between the input register and the result register. A stalled result stops
// the input register from taking a further byte once it holds one.
module avcc_record_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  avcc_rp_pkg::in_beat_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output avcc_rp_pkg::out_beat_t out_data_o
);
  import avcc_rp_pkg::*;

  logic      in_valid_q;
  logic      in_valid_d;
  in_beat_t  in_beat_q;
  logic      out_valid_q;
  logic      out_valid_d;
  out_beat_t out_beat_q;
  out_beat_t step_res;
  logic      out_ready;
  logic      adv;
  logic      in_take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_ready ? adv : out_valid_q;
  end

  avcc_rp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (adv),
    .beat_i    (in_beat_q),
    .res_o     (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_beat_q <= in_data_i;
    end
    if (adv) begin
      out_beat_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_beat_q;

endmodule

// ----- rtl/core/avcc_rp_checker.sv -----
// port-level checker for the avcc record parser and its bind
`include "avcc_record_parser_macros.svh"

module avcc_rp_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input avcc_rp_pkg::in_beat_t  in_data_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input avcc_rp_pkg::out_beat_t out_data_o
);
  import avcc_rp_pkg::*;

  logic in_seen;
  assign in_seen = in_valid_i && !in_stall_o;

  `AVCC_RP_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "result beat changed while stalled")
  `AVCC_RP_ASSERT_IMP(a_summary_only_on_done, out_valid_o && !out_data_o.record_done, out_data_o.status == ST_OK && out_data_o.length_size == 3'd0 && out_data_o.sps_total == 5'd0 && out_data_o.pps_total == 8'd0, "summary fields set on a beat that is not the last")
  `AVCC_RP_ASSERT_IMP(a_header_beat_clean, out_valid_o && out_data_o.kind == KIND_HDR, out_data_o.payload == 8'd0 && !out_data_o.unit_start && !out_data_o.unit_end, "header beat carries payload or unit marks")
  `AVCC_RP_ASSERT_IMP(a_error_no_length, out_valid_o && out_data_o.status != ST_OK, out_data_o.length_size == 3'd0, "length size reported on a failed record")
  `AVCC_RP_ASSERT_NXT(a_no_result_from_idle, !in_seen && !$past(in_seen) && !out_valid_o, !out_valid_o, "result beat with no byte accepted")

endmodule

bind avcc_record_parser avcc_rp_checker u_avcc_rp_checker (.*);

// ----- bench/tb_avcc_record_parser.sv -----
// self-checking testbench for the avcc record parser
`timescale 1ns / 1ps

module tb_avcc_record_parser;
  import avcc_rp_pkg::*;

  localparam int DirectedCount = 26;
  localparam int ParsedTarget  = 1375;
  localparam int CalmFrom      = 1150;
  localparam int CycleLimit    = 400000;

  typedef struct packed {
    in_beat_t  beat;
    logic      typed;
    out_beat_t want;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;

  logic      row_typed = 1'b0;
  out_beat_t row_want = '0;

  phase_e      ps_phase;
  logic [2:0]  ps_hdr_pos;
  logic [7:0]  ps_units_left;
  logic [15:0] ps_bytes_left;
  logic [7:0]  ps_len_high;
  logic [2:0]  ps_len_size;
  logic        ps_bad_version;
  logic [4:0]  ps_sps_count;
  logic [7:0]  ps_pps_count;

  out_beat_t   expected_beats[$];
  logic [7:0]  rec_bytes[$];
  stim_row_t   directed_rows [DirectedCount];
  int          mismatch_count = 0;
  int          parsed_bytes = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  int          out_index = 0;
  bit          calm = 1'b0;

  avcc_record_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void clear_parse_state();
    ps_phase       = PH_HEADER;
    ps_hdr_pos     = '0;
    ps_units_left  = '0;
    ps_bytes_left  = '0;
    ps_len_high    = '0;
    ps_len_size    = '0;
    ps_bad_version = 1'b0;
    ps_sps_count   = '0;
    ps_pps_count   = '0;
  endfunction

  function automatic void close_unit(input logic is_pps);
    if (ps_units_left != 8'd0) ps_units_left = ps_units_left - 8'd1;
    if (!is_pps) begin
      ps_phase = (ps_units_left == 8'd0) ? PH_PPS_COUNT : PH_SPS_HI;
    end else begin
      ps_phase = (ps_units_left == 8'd0) ? PH_TRAILER : PH_PPS_HI;
    end
  endfunction

  function automatic out_beat_t parse_byte(input in_beat_t beat);
    out_beat_t  r;
    logic [7:0] b;
    logic       is_pps;
    status_e    st;
    r = '0;
    b = beat.data_byte;
    case (ps_phase)
      PH_HEADER: begin
        if (ps_hdr_pos == HdrVersionPos && b != VersionOne) begin
          ps_bad_version = 1'b1;
          ps_phase = PH_HALT;
        end else begin
          if (ps_hdr_pos == HdrLenPos) ps_len_size = {1'b0, b[1:0]} + 3'd1;
          if (ps_hdr_pos >= HdrSpsPos) begin
            ps_sps_count  = b[4:0];
            ps_units_left = {3'b000, b[4:0]};
            ps_phase = (b[4:0] != 5'd0) ? PH_SPS_HI : PH_PPS_COUNT;
          end else begin
            ps_hdr_pos = ps_hdr_pos + 3'd1;
          end
        end
      end
      PH_SPS_HI, PH_PPS_HI: begin
        ps_len_high = b;
        ps_phase = phase_e'(ps_phase + 4'd1);
      end
      PH_SPS_LO, PH_PPS_LO: begin
        ps_bytes_left = {ps_len_high, b};
        if (ps_bytes_left == 16'd0) begin
          close_unit(ps_phase == PH_PPS_LO);
        end else begin
          ps_phase = phase_e'(ps_phase + 4'd1);
        end
      end
      PH_SPS_FIRST, PH_SPS_BODY, PH_PPS_FIRST, PH_PPS_BODY: begin
        is_pps = ps_phase inside {PH_PPS_FIRST, PH_PPS_BODY};
        r.kind = is_pps ? KIND_PPS : KIND_SPS;
        r.payload = b;
        r.unit_start = ps_phase inside {PH_SPS_FIRST, PH_PPS_FIRST};
        ps_bytes_left = ps_bytes_left - 16'd1;
        if (ps_bytes_left == 16'd0) begin
          r.unit_end = 1'b1;
          close_unit(is_pps);
        end else begin
          ps_phase = is_pps ? PH_PPS_BODY : PH_SPS_BODY;
        end
      end
      PH_PPS_COUNT: begin
        ps_pps_count  = b;
        ps_units_left = b;
        ps_phase = (b != 8'd0) ? PH_PPS_HI : PH_TRAILER;
      end
      default: begin
      end
    endcase
    r.record_done = beat.last;
    if (beat.last) begin
      if (ps_bad_version) st = ST_BAD_VERSION;
      else if (ps_phase == PH_TRAILER) st = ST_OK;
      else st = ST_TRUNCATED;
      r.status      = st;
      r.length_size = (st == ST_OK) ? ps_len_size : 3'd0;
      r.sps_total   = ps_sps_count;
      r.pps_total   = ps_pps_count;
      clear_parse_state();
    end
    return r;
  endfunction

  function automatic stim_row_t plain_row(input logic [7:0] b, input logic l);
    stim_row_t r;
    r = '0;
    r.beat.data_byte = b;
    r.beat.last = l;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] b, input logic l,
                                          input out_beat_t want);
    stim_row_t r;
    r = plain_row(b, l);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic out_beat_t done_beat(input status_e st, input logic [2:0] len,
                                          input logic [4:0] sps, input logic [7:0] pps);
    out_beat_t r;
    r = '0;
    r.record_done = 1'b1;
    r.status = st;
    r.length_size = len;
    r.sps_total = sps;
    r.pps_total = pps;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("[%0t] beat %0d: %s", $time, out_index, msg);
    mismatch_count++;
  endtask

  task automatic check_beat(input out_beat_t got, input out_beat_t want);
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.payload !== want.payload)
      report_mismatch($sformatf("payload %h, want %h", got.payload, want.payload));
    if (got.unit_start !== want.unit_start)
      report_mismatch($sformatf("unit_start %b, want %b", got.unit_start, want.unit_start));
    if (got.unit_end !== want.unit_end)
      report_mismatch($sformatf("unit_end %b, want %b", got.unit_end, want.unit_end));
    if (got.record_done !== want.record_done)
      report_mismatch($sformatf("record_done %b, want %b", got.record_done, want.record_done));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.length_size !== want.length_size)
      report_mismatch($sformatf("length_size %0d, want %0d", got.length_size,
                                want.length_size));
    if (got.sps_total !== want.sps_total)
      report_mismatch($sformatf("sps_total %0d, want %0d", got.sps_total, want.sps_total));
    if (got.pps_total !== want.pps_total)
      report_mismatch($sformatf("pps_total %0d, want %0d", got.pps_total, want.pps_total));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          check_beat(out_data_o, expected_beats.pop_front());
        end
        out_index++;
      end
      if (in_valid_i && !in_stall_o) begin
        if (!(ps_phase inside {PH_TRAILER, PH_HALT})) parsed_bytes++;
        if (row_typed) begin
          void'(parse_byte(in_data_i));
          expected_beats.push_back(row_want);
        end else begin
          expected_beats.push_back(parse_byte(in_data_i));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_byte(input in_beat_t beat, input logic typed, input out_beat_t want);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    row_typed  <= typed;
    row_want   <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic push_unit(input int mode);
    int len;
    int body;
    if (mode == 2) len = $urandom_range(0, 65535);
    else if (mode == 1) len = $urandom_range(0, 2);
    else if ($urandom_range(0, 15) == 0) len = $urandom_range(7, 300);
    else len = $urandom_range(0, 6);
    body = (mode == 2 && len > 12) ? 12 : len;
    rec_bytes.push_back(len[15:8]);
    rec_bytes.push_back(len[7:0]);
    repeat (body) rec_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_record();
    int         style;
    int         mode;
    int         n_pps;
    int         cut;
    logic [4:0] n_sps;
    logic [7:0] b;
    rec_bytes.delete();
    style = $urandom_range(0, 99);
    if (style < 10) begin
      repeat ($urandom_range(1, 6)) rec_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      mode = (style >= 97) ? 1 : (style >= 20 && style < 30) ? 2 : 0;
      b = (style < 14) ? 8'($urandom_range(0, 255)) : VersionOne;
      rec_bytes.push_back(b);
      repeat (4) rec_bytes.push_back(8'($urandom_range(0, 255)));
      n_sps = (mode == 1) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3));
      b = 8'($urandom_range(0, 255));
      rec_bytes.push_back({b[7:5], n_sps});
      repeat (n_sps) push_unit(mode);
      n_pps = (mode == 1) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      rec_bytes.push_back(n_pps[7:0]);
      repeat (n_pps) push_unit(mode);
      repeat ($urandom_range(0, 3)) rec_bytes.push_back(8'($urandom_range(0, 255)));
      if (style >= 14 && style < 34) begin
        cut = $urandom_range(1, rec_bytes.size());
        while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
      end
    end
  endtask

  initial begin
    in_beat_t beat;
    clear_parse_state();
    directed_rows = '{
      typed_row(8'h00, 1'b1, done_beat(ST_BAD_VERSION, 3'd0, 5'd0, 8'd0)),
      typed_row(8'hFF, 1'b0, '0),
      typed_row(8'h80, 1'b1, done_beat(ST_BAD_VERSION, 3'd0, 5'd0, 8'd0)),
      typed_row(8'h01, 1'b0, '0),
      plain_row(8'h64, 1'b0),
      plain_row(8'h00, 1'b0),
      plain_row(8'h1F, 1'b0),
      plain_row(8'hFF, 1'b0),
      plain_row(8'hE2, 1'b0),
      plain_row(8'h00, 1'b0),
      plain_row(8'h02, 1'b0),
      plain_row(8'h00, 1'b0),
      plain_row(8'hFF, 1'b0),
      plain_row(8'h00, 1'b0),
      plain_row(8'h00, 1'b0),
      plain_row(8'h01, 1'b0),
      plain_row(8'h00, 1'b0),
      plain_row(8'h01, 1'b0),
      plain_row(8'h5A, 1'b0),
      typed_row(8'hC7, 1'b1, done_beat(ST_OK, 3'd4, 5'd2, 8'd1)),
      plain_row(8'h01, 1'b0),
      plain_row(8'h00, 1'b0),
      plain_row(8'h00, 1'b0),
      plain_row(8'h00, 1'b0),
      plain_row(8'hFC, 1'b0),
      typed_row(8'h01, 1'b1, done_beat(ST_TRUNCATED, 3'd0, 5'd1, 8'd0))
    };
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    while (parsed_bytes < ParsedTarget) begin
      build_record();
      foreach (rec_bytes[i]) begin
        beat.data_byte = rec_bytes[i];
        beat.last = (i == rec_bytes.size() - 1);
        send_byte(beat, 1'b0, '0);
      end
      if (parsed_bytes >= CalmFrom) calm = 1'b1;
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
